FILE: rtl/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

  typedef enum logic [1:0] {
    KIND_SQUARE = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_RECT   = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_e;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned SIZE_W = 14;
  localparam int unsigned WORK_W = 22;
  localparam int unsigned PROD_W = 2 * WORK_W;

  localparam logic [SIZE_W-1:0] GRID_LEN_RESET = 14'd512;

  // 3.0 at 4 fraction bits
  localparam logic signed [WORK_W-1:0] SQ_MARGIN = 22'sd48;
  // 2.0 and 4.0 at 6 fraction bits
  localparam logic signed [WORK_W-1:0] TOP_INSET    = 22'sd128;
  localparam logic signed [WORK_W-1:0] BOTTOM_INSET = 22'sd256;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
    kind_e                   kind;
  } shape_t;

endpackage

FILE: rtl/scp_tests.sv
`timescale 1ns / 1ps

module scp_tests (
  input  scp_pkg::shape_t               a_i,
  input  scp_pkg::shape_t               b_i,
  input  logic [scp_pkg::SIZE_W-1:0]    grid_len_i,
  output logic                          hit_o
);
  import scp_pkg::*;

  // all arithmetic at 6 fraction bits
  function automatic logic signed [WORK_W-1:0] pos6(input logic signed [POS_W-1:0] v);
    pos6 = $signed({{(WORK_W-POS_W-2){v[POS_W-1]}}, v, 2'b00});
  endfunction

  function automatic logic signed [WORK_W-1:0] size6(input logic [SIZE_W-1:0] v);
    size6 = $signed({{(WORK_W-SIZE_W-2){1'b0}}, v, 2'b00});
  endfunction

  function automatic logic signed [WORK_W-1:0] half6(input logic [SIZE_W-1:0] v);
    half6 = $signed({{(WORK_W-SIZE_W-1){1'b0}}, v, 1'b0});
  endfunction

  function automatic logic signed [WORK_W-1:0] quarter6(input logic [SIZE_W-1:0] v);
    quarter6 = $signed({{(WORK_W-SIZE_W){1'b0}}, v});
  endfunction

  function automatic logic signed [WORK_W-1:0] absv(input logic signed [WORK_W-1:0] v);
    absv = v[WORK_W-1] ? -v : v;
  endfunction

  logic signed [WORK_W-1:0] pax, pay, pbx, pby;
  logic signed [WORK_W-1:0] acx, acy, bcx, bcy;
  logic signed [WORK_W-1:0] lim, ul_ext;
  logic                     hit_sq;

  logic signed [WORK_W-1:0] dx, dy, rs;
  logic                     both_circ;

  shape_t                   c_s, r_s;
  logic signed [WORK_W-1:0] d_x, d_y, rad, hw, hh, ex, ey;
  logic                     cb_out, cb_edge;

  logic signed [WORK_W-1:0] sq_a, sq_b, sq_c;
  logic signed [PROD_W-1:0] prod_a, prod_b, prod_c;
  logic signed [PROD_W:0]   dist2, lim2;
  logic                     hit_cc, hit_cb;

  logic signed [WORK_W-1:0] ax1, ax2, bx1, bx2, ay1, ay2, by1, by2;
  logic                     va, vb, hit_box;

  assign pax = pos6(a_i.x);
  assign pay = pos6(a_i.y);
  assign pbx = pos6(b_i.x);
  assign pby = pos6(b_i.y);
  assign acx = pax + half6(a_i.w);
  assign acy = pay + half6(a_i.h);
  assign bcx = pbx + half6(b_i.w);
  assign bcy = pby + half6(b_i.h);

  // square pair
  assign ul_ext = $signed({{(WORK_W-SIZE_W){1'b0}}, grid_len_i});
  assign lim    = (ul_ext - SQ_MARGIN) <<< 2;
  assign hit_sq = (absv(acx - bcx) < lim) && (absv(acy - bcy) < lim);

  // circle pair
  assign both_circ = (a_i.kind == KIND_CIRCLE) && (b_i.kind == KIND_CIRCLE);
  assign dx = bcx - acx;
  assign dy = bcy - acy;
  assign rs = half6(a_i.w) + half6(b_i.w);

  // circle against another shape, corner positions
  assign c_s = (a_i.kind == KIND_CIRCLE) ? a_i : b_i;
  assign r_s = (a_i.kind == KIND_CIRCLE) ? b_i : a_i;
  assign d_x = absv(pos6(c_s.x) - pos6(r_s.x));
  assign d_y = absv(pos6(c_s.y) - pos6(r_s.y));
  assign rad = quarter6(c_s.w);
  assign hw  = (r_s.kind == KIND_RECT) ? half6(r_s.w) : quarter6(r_s.w);
  assign hh  = half6(r_s.h);
  assign ex  = d_x - hw;
  assign ey  = d_y - hh;
  assign cb_out  = (d_x > hw + rad) || (d_y > hh + rad);
  assign cb_edge = (d_x <= hw) || (d_y <= hh);

  // squarers shared by the two circle tests
  assign sq_a   = both_circ ? dx : ex;
  assign sq_b   = both_circ ? dy : ey;
  assign sq_c   = both_circ ? rs : rad;
  assign prod_a = sq_a * sq_a;
  assign prod_b = sq_b * sq_b;
  assign prod_c = sq_c * sq_c;
  assign dist2  = {prod_a[PROD_W-1], prod_a} + {prod_b[PROD_W-1], prod_b};
  assign lim2   = {prod_c[PROD_W-1], prod_c};
  assign hit_cc = dist2 < lim2;
  assign hit_cb = !cb_out && (cb_edge || (dist2 <= lim2));

  // box overlap
  always_comb begin
    va  = 1'b1;
    ax1 = pax;
    ax2 = pax + size6(a_i.w);
    case (a_i.kind)
      KIND_SQUARE: ;
      KIND_RECT: begin
        ax1 = acx - quarter6(a_i.w);
        ax2 = acx + quarter6(a_i.w);
      end
      default: va = 1'b0;
    endcase
    vb  = 1'b1;
    bx1 = pbx;
    bx2 = pbx + size6(b_i.w);
    case (b_i.kind)
      KIND_SQUARE: ;
      KIND_RECT: begin
        bx1 = bcx - quarter6(b_i.w);
        bx2 = bcx + quarter6(b_i.w);
      end
      default: vb = 1'b0;
    endcase
  end

  assign ay1 = pay + TOP_INSET;
  assign ay2 = pay + size6(a_i.h);
  assign by1 = pby;
  assign by2 = pby + size6(b_i.h) - ((b_i.kind == KIND_RECT) ? BOTTOM_INSET : '0);
  assign hit_box = va && vb && (ax1 < bx2) && (ax2 > bx1) && (ay1 < by2) && (ay2 > by1);

  always_comb begin
    if (a_i.kind == KIND_SQUARE && b_i.kind == KIND_SQUARE) begin
      hit_o = hit_sq;
    end else if (both_circ) begin
      hit_o = hit_cc;
    end else if (a_i.kind == KIND_CIRCLE || b_i.kind == KIND_CIRCLE) begin
      hit_o = hit_cb;
    end else begin
      hit_o = hit_box;
    end
  end

endmodule

FILE: rtl/shape_pair_collision_test_top.sv
`timescale 1ns / 1ps

// Shape pair collision test. One pair of shapes is taken per clock while
// the input is not stalled: the pair is captured in an input register, the
// test for the pair of kinds (square, box, distance or corner test, the
// last two using three shared squarers) is evaluated in one pass, and the
// hit flag is held in a result register. A stalled result holds that
// register; the input register keeps taking items as long as the result
// moves on. The grid length is written through cfg_we_i/cfg_data_i, by the
// user only while no item is in flight (the block does not enforce this); it resets to 32.0.

module shape_pair_collision_test_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scp_pkg::SIZE_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [scp_pkg::POS_W-1:0] a_x_i,
  input  logic signed [scp_pkg::POS_W-1:0] a_y_i,
  input  logic [scp_pkg::SIZE_W-1:0]      a_w_i,
  input  logic [scp_pkg::SIZE_W-1:0]      a_h_i,
  input  logic [1:0]                      a_kind_i,
  input  logic signed [scp_pkg::POS_W-1:0] b_x_i,
  input  logic signed [scp_pkg::POS_W-1:0] b_y_i,
  input  logic [scp_pkg::SIZE_W-1:0]      b_w_i,
  input  logic [scp_pkg::SIZE_W-1:0]      b_h_i,
  input  logic [1:0]                      b_kind_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o
);
  import scp_pkg::*;

  logic [SIZE_W-1:0] grid_len_q;
  shape_t            a_q, b_q;
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              hit_q, hit_d;
  logic              out_free;
  logic              hit_comb;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;

  always_comb begin
    s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
    hit_d       = (out_free && s1_valid_q) ? hit_comb : hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_len_q  <= GRID_LEN_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        grid_len_q <= cfg_data_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      a_q <= '{x: a_x_i, y: a_y_i, w: a_w_i, h: a_h_i, kind: kind_e'(a_kind_i)};
      b_q <= '{x: b_x_i, y: b_y_i, w: b_w_i, h: b_h_i, kind: kind_e'(b_kind_i)};
    end
    hit_q <= hit_d;
  end

  scp_tests u_tests (
    .a_i        (a_q),
    .b_i        (b_q),
    .grid_len_i (grid_len_q),
    .hit_o      (hit_comb)
  );

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("held item dropped from input register");

  a_s1_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free) |=> out_valid_o)
    else $error("item lost on the way to the result register");

  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |-> !in_stall_o)
    else $error("input stalled with result register empty");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (grid_len_q == $past(cfg_data_i)))
    else $error("grid length write not taken");

endmodule
